// ----- hdl/interpolation_search_defines.svh -----
// ----------------------------------------------------------------------------
// interpolation_search_defines.svh
// Assertion macros used by the checker of the interpolation search.
// ----------------------------------------------------------------------------
`ifndef INTERPOLATION_SEARCH_DEFINES_SVH
`define INTERPOLATION_SEARCH_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ISRCH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ISRCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/isrch_pkg.sv -----
// ----------------------------------------------------------------------------
// isrch_pkg
// Sizes, command codes and word types of the interpolation search block.
// ----------------------------------------------------------------------------
package isrch_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int N_W          = ADDR_W + 1;     // holds 0..MAX_ELEMENTS
    localparam int CNT_W        = 11;
    localparam int IDX_W        = 10;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 10;
    localparam int MAG_W        = VAL_W;          // |a - b| of two words fits here
    localparam int NUM_W        = MAG_W + ADDR_W; // |key - low| * index span

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [IDX_W-1:0]         index;
        logic signed [VAL_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } result_t;

endpackage

// ----- hdl/isrch_ram.sv -----
// ----------------------------------------------------------------------------
// isrch_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module isrch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/isrch_div.sv -----
// ----------------------------------------------------------------------------
// isrch_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module isrch_div
    import isrch_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [MAG_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(NUM_W);

    logic              run_reg,  run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [MAG_W-1:0]  rem_reg,  rem_next;
    logic [NUM_W-1:0]  quo_reg,  quo_next;
    logic [MAG_W-1:0]  dvs_reg,  dvs_next;
    logic [MAG_W+1:0]  trial;
    logic              fits;

    // shift in the next dividend bit and try the subtract
    assign trial = {1'b0, rem_reg, quo_reg[NUM_W-1]} - {2'b00, dvs_reg};
    assign fits  = !trial[MAG_W+1];

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (run_reg)
        begin
            rem_next  = fits ? trial[MAG_W-1:0] : {rem_reg[MAG_W-2:0], quo_reg[NUM_W-1]};
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(NUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/interpolation_search.sv -----
// ----------------------------------------------------------------------------
// interpolation_search
// Write word: busy stays low. Search on an empty array: result strobe the
// next cycle. Otherwise RLO, RHI and EVAL read both ends and check bounds, then
// each probe runs MUL, DIV (bit-serial divider), RP, RP1, PCHK; MUL and DIV are
// skipped when both ends are equal. A new word is taken only while busy is low.
// Results cannot be stalled. rst_n clears control state and count_reg; the store is not cleared.
// ----------------------------------------------------------------------------
module interpolation_search
    import isrch_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    output logic             done,
    output result_t          result,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RLO  = 4'd1;
    localparam logic [3:0] ST_RHI  = 4'd2;
    localparam logic [3:0] ST_EVAL = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_RP   = 4'd6;
    localparam logic [3:0] ST_RP1  = 4'd7;
    localparam logic [3:0] ST_PCHK = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [N_W-1:0]          lo_reg, lo_next;
    logic [ADDR_W-1:0]       hi_reg, hi_next;
    logic [ADDR_W-1:0]       pos_reg, pos_next;
    logic signed [VAL_W-1:0] key_reg, key_next;
    logic signed [VAL_W-1:0] vlo_reg, vlo_next;
    logic signed [VAL_W-1:0] vp_reg, vp_next;
    logic                    first_reg, first_next;
    logic                    dneg_reg, dneg_next;
    logic [MAG_W-1:0]        dmag_reg, dmag_next;
    logic                    qneg_reg, qneg_next;
    logic                    done_reg, done_next;
    result_t                 result_reg, result_next;

    logic                    accept;
    logic [N_W-1:0]          n_eff;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;
    logic signed [VAL_W-1:0] rd_val;
    logic                    ram_we;

    logic [MAG_W:0]          den_w, diff_w, den_abs, diff_abs;
    logic [ADDR_W-1:0]       span;
    logic [NUM_W-1:0]        prod_w;
    logic                    div_start, div_done;
    logic [NUM_W-1:0]        div_quo;
    logic [N_W-1:0]          pos_inc;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign rd_val = ram_rdata;

    always_comb
    begin
        if (int'(count_reg) > MAX_ELEMENTS)
        begin
            n_eff = N_W'(MAX_ELEMENTS);
        end
        else
        begin
            n_eff = N_W'(count_reg);
        end
    end

    assign ram_we = accept && (cmd.func == FUNC_WRITE) && (int'(cmd.index) < MAX_ELEMENTS);

    isrch_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(cmd.index)),
        .wdata (cmd.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // probe arithmetic on magnitudes; the sign is kept apart
    assign den_w    = {rd_val[VAL_W-1], rd_val} - {vlo_reg[VAL_W-1], vlo_reg};
    assign den_abs  = den_w[MAG_W] ? (~den_w + 1'b1) : den_w;
    assign diff_w   = {key_reg[VAL_W-1], key_reg} - {vlo_reg[VAL_W-1], vlo_reg};
    assign diff_abs = diff_w[MAG_W] ? (~diff_w + 1'b1) : diff_w;
    assign span     = hi_reg - lo_reg[ADDR_W-1:0];
    assign prod_w   = NUM_W'(diff_abs[MAG_W-1:0]) * NUM_W'(span);
    assign div_start = (state_reg == ST_MUL);
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;

    isrch_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_w),
        .divisor  (dmag_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        vlo_next    = vlo_reg;
        vp_next     = vp_reg;
        first_next  = first_reg;
        dneg_next   = dneg_reg;
        dmag_next   = dmag_reg;
        qneg_next   = qneg_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ram_raddr   = lo_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.func == FUNC_SEARCH))
                begin
                    key_next   = cmd.value;
                    lo_next    = '0;
                    hi_next    = ADDR_W'(n_eff - 1'b1);
                    first_next = 1'b1;
                    if (n_eff == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                    else
                    begin
                        state_next = ST_RLO;
                    end
                end
            end
            ST_RLO:
            begin
                ram_raddr  = lo_reg[ADDR_W-1:0];
                state_next = ST_RHI;
            end
            ST_RHI:
            begin
                ram_raddr  = hi_reg;
                vlo_next   = rd_val;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                first_next = 1'b0;
                dneg_next  = den_w[MAG_W];
                dmag_next  = den_abs[MAG_W-1:0];
                if (first_reg && ((key_reg < vlo_reg) || (key_reg > rd_val)))
                begin
                    done_next   = 1'b1;
                    result_next = '0;
                    state_next  = ST_IDLE;
                end
                else if (lo_reg >= {1'b0, hi_reg})
                begin
                    // range closed: only the low element can still match
                    done_next = 1'b1;
                    if ((lo_reg < n_eff) && (vlo_reg == key_reg))
                    begin
                        result_next.found    = 1'b1;
                        result_next.position = POS_W'(lo_reg);
                    end
                    else
                    begin
                        result_next = '0;
                    end
                    state_next = ST_IDLE;
                end
                else if (rd_val == vlo_reg)
                begin
                    pos_next   = lo_reg[ADDR_W-1:0];
                    state_next = ST_RP;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                qneg_next  = diff_w[MAG_W] ^ dneg_reg;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    // quotient truncates toward zero; clamp into [lo, hi]
                    if (qneg_reg)
                    begin
                        pos_next = lo_reg[ADDR_W-1:0];
                    end
                    else if (div_quo > NUM_W'(span))
                    begin
                        pos_next = hi_reg;
                    end
                    else
                    begin
                        pos_next = lo_reg[ADDR_W-1:0] + div_quo[ADDR_W-1:0];
                    end
                    state_next = ST_RP;
                end
            end
            ST_RP:
            begin
                ram_raddr  = pos_reg;
                state_next = ST_RP1;
            end
            ST_RP1:
            begin
                ram_raddr  = pos_inc[ADDR_W-1:0];
                vp_next    = rd_val;
                state_next = ST_PCHK;
            end
            ST_PCHK:
            begin
                if (vp_reg == key_reg)
                begin
                    done_next            = 1'b1;
                    result_next.found    = 1'b1;
                    result_next.position = POS_W'(pos_reg);
                    state_next           = ST_IDLE;
                end
                else if ((pos_inc < n_eff) && (key_reg > vp_reg) && (key_reg < rd_val))
                begin
                    done_next   = 1'b1;
                    result_next = '0;
                    state_next  = ST_IDLE;
                end
                else if (vp_reg > key_reg)
                begin
                    if ({1'b0, pos_reg} == lo_reg)
                    begin
                        // hi drops below lo; the low element is the miss just seen
                        done_next   = 1'b1;
                        result_next = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        hi_next    = pos_reg - 1'b1;
                        state_next = ST_RLO;
                    end
                end
                else
                begin
                    lo_next    = pos_inc;
                    state_next = ST_RLO;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            first_reg <= first_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        vlo_reg    <= vlo_next;
        vp_reg     <= vp_next;
        dneg_reg   <= dneg_next;
        dmag_reg   <= dmag_next;
        qneg_reg   <= qneg_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- hdl/isrch_checker.sv -----
// ----------------------------------------------------------------------------
// isrch_checker
// Port-level checks of the interpolation search, bound to the top level.
// ----------------------------------------------------------------------------
`include "interpolation_search_defines.svh"

module isrch_checker
    import isrch_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input cmd_t    cmd,
    input logic    done,
    input result_t result
);

    `ISRCH_ASSERT_NEXT(a_write_no_result, start && !busy && (cmd.func == FUNC_WRITE), !done, "write word produced a result")
    `ISRCH_ASSERT_NEXT(a_search_responds, start && !busy && (cmd.func == FUNC_SEARCH), busy || done, "search word neither started nor answered")
    `ISRCH_ASSERT_SAME(a_finish_strobes, $fell(busy), done, "search finished without a result strobe")
    `ISRCH_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while still busy")
    `ISRCH_ASSERT_SAME(a_miss_pos_zero, done && !result.found, result.position == '0, "miss reported with nonzero position")

endmodule

bind interpolation_search isrch_checker u_isrch_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);
